FILE: src/obrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obrb_pkg
// Shared types and constants of the overwriting byte ring buffer.
// ----------------------------------------------------------------------------
package obrb_pkg;

  localparam int DEPTH      = 64;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int FILL_W     = $clog2(DEPTH + 1);
  localparam int CFG_W      = 7;
  localparam int BYTE_W     = 8;
  localparam int FUNC_W     = 3;
  localparam int OUT_FILL_W = 7;
  localparam int TDATA_IN_W = 8;
  localparam int TDATA_OUT_W = 16;

  // Result queue ahead of the output port.
  localparam int OUT_DEPTH = 3;
  localparam int OPTR_W    = $clog2(OUT_DEPTH);
  localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH  = 3'd0,
    FUNC_POP   = 3'd1,
    FUNC_PEEK  = 3'd2,
    FUNC_DUMP  = 3'd3,
    FUNC_DRAIN = 3'd4
  } func_e;

  // Result fields known when the store access is issued.
  typedef struct packed {
    logic              use_ram;
    logic [FILL_W-1:0] fill;
    logic              was_empty;
    logic              full;
    logic              last;
  } res_meta_t;

  // Complete result word as it waits for the output port.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [FILL_W-1:0] fill;
    logic              was_empty;
    logic              full;
    logic              last;
  } res_item_t;

endpackage

FILE: src/obrb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obrb_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module obrb_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: src/obrb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obrb_ctrl
// Ring index bookkeeping, store access sequencing and result descriptors.
// ----------------------------------------------------------------------------
module obrb_ctrl
  import obrb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FUNC_W-1:0] in_func_i,
  input  logic [BYTE_W-1:0] in_data_i,
  input  logic              in_last_i,
  input  logic              room_i,
  output logic              mem_we_o,
  output logic [IDX_W-1:0]  mem_waddr_o,
  output logic [BYTE_W-1:0] mem_wdata_o,
  output logic              mem_re_o,
  output logic [IDX_W-1:0]  mem_raddr_o,
  output logic              pend_valid_o,
  output res_meta_t         pend_meta_o
);

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_e;

  localparam logic [CFG_W-1:0] CFG_DEPTH = CFG_W'(DEPTH);

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  widx_q, widx_d;
  logic [IDX_W-1:0]  ridx_q, ridx_d;
  logic              full_q, full_d;
  logic [FILL_W-1:0] size_q, size_d;
  logic [IDX_W-1:0]  didx_q, didx_d;
  logic [FILL_W-1:0] remain_q, remain_d;
  logic [FILL_W-1:0] dfill_q, dfill_d;
  logic              dfull_q, dfull_d;
  logic              drain_q, drain_d;
  logic              pend_valid_q, pend_valid_d;
  res_meta_t         pend_meta_q, pend_meta_d;

  function automatic logic [IDX_W-1:0] bump(input logic [IDX_W-1:0] idx,
                                            input logic [FILL_W-1:0] size);
    logic [FILL_W-1:0] nxt;
    nxt = FILL_W'(idx) + FILL_W'(1);
    return (nxt >= size) ? '0 : nxt[IDX_W-1:0];
  endfunction

  function automatic logic [FILL_W-1:0] fill_of(input logic [IDX_W-1:0] w,
                                                input logic [IDX_W-1:0] r,
                                                input logic full,
                                                input logic [FILL_W-1:0] size);
    if (w == r) begin
      return full ? size : '0;
    end else if (w > r) begin
      return FILL_W'(w) - FILL_W'(r);
    end
    return size - FILL_W'(r) + FILL_W'(w);
  endfunction

  function automatic res_meta_t empty_meta();
    res_meta_t m;
    m.use_ram   = 1'b0;
    m.fill      = '0;
    m.was_empty = 1'b1;
    m.full      = 1'b0;
    m.last      = 1'b1;
    return m;
  endfunction

  logic [FILL_W-1:0] fill_now;
  logic              accept;

  assign fill_now   = fill_of(widx_q, ridx_q, full_q, size_q);
  assign in_ready_o = (state_q == ST_IDLE) && room_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    logic [IDX_W-1:0] w_n;
    logic [IDX_W-1:0] r_n;
    logic             f_n;
    logic [CFG_W-1:0] clamp;

    w_n          = widx_q;
    r_n          = ridx_q;
    f_n          = full_q;
    clamp        = cfg_wdata_i;
    state_d      = state_q;
    widx_d       = widx_q;
    ridx_d       = ridx_q;
    full_d       = full_q;
    size_d       = size_q;
    didx_d       = didx_q;
    remain_d     = remain_q;
    dfill_d      = dfill_q;
    dfull_d      = dfull_q;
    drain_d      = drain_q;
    pend_valid_d = 1'b0;
    pend_meta_d  = pend_meta_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = widx_q;
    mem_wdata_o  = in_data_i;
    mem_re_o     = 1'b0;
    mem_raddr_o  = ridx_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (func_e'(in_func_i))
            FUNC_PUSH: begin
              mem_we_o = 1'b1;
              r_n      = full_q ? bump(ridx_q, size_q) : ridx_q;
              w_n      = bump(widx_q, size_q);
              f_n      = (w_n == r_n);
              widx_d   = w_n;
              ridx_d   = r_n;
              full_d   = f_n;
              if (in_last_i) begin
                pend_valid_d          = 1'b1;
                pend_meta_d.use_ram   = 1'b0;
                pend_meta_d.fill      = fill_of(w_n, r_n, f_n, size_q);
                pend_meta_d.was_empty = 1'b0;
                pend_meta_d.full      = f_n;
                pend_meta_d.last      = 1'b1;
              end
            end
            FUNC_POP, FUNC_PEEK: begin
              pend_valid_d = 1'b1;
              if (fill_now == '0) begin
                pend_meta_d = empty_meta();
              end else begin
                mem_re_o = 1'b1;
                if (func_e'(in_func_i) == FUNC_POP) begin
                  r_n = bump(ridx_q, size_q);
                  f_n = 1'b0;
                end
                ridx_d                = r_n;
                full_d                = f_n;
                pend_meta_d.use_ram   = 1'b1;
                pend_meta_d.fill      = fill_of(widx_q, r_n, f_n, size_q);
                pend_meta_d.was_empty = 1'b0;
                pend_meta_d.full      = f_n;
                pend_meta_d.last      = 1'b1;
              end
            end
            FUNC_DUMP, FUNC_DRAIN: begin
              if (fill_now == '0) begin
                pend_valid_d = 1'b1;
                pend_meta_d  = empty_meta();
              end else begin
                state_d  = ST_DUMP;
                didx_d   = ridx_q;
                remain_d = fill_now;
                drain_d  = (func_e'(in_func_i) == FUNC_DRAIN);
                dfill_d  = drain_d ? '0 : fill_now;
                dfull_d  = !drain_d && full_q;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DUMP: begin
        if (room_i) begin
          mem_re_o              = 1'b1;
          mem_raddr_o           = didx_q;
          pend_valid_d          = 1'b1;
          pend_meta_d.use_ram   = 1'b1;
          pend_meta_d.fill      = dfill_q;
          pend_meta_d.was_empty = 1'b0;
          pend_meta_d.full      = dfull_q;
          pend_meta_d.last      = (remain_q == FILL_W'(1));
          didx_d                = bump(didx_q, size_q);
          remain_d              = remain_q - FILL_W'(1);
          if (remain_q == FILL_W'(1)) begin
            state_d = ST_IDLE;
            if (drain_q) begin
              widx_d = '0;
              ridx_d = '0;
              full_d = 1'b0;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A size write empties the store; the user keeps it to idle; not enforced.
    if (cfg_we_i) begin
      if (clamp == '0) begin
        clamp = CFG_W'(1);
      end else if (clamp > CFG_DEPTH) begin
        clamp = CFG_DEPTH;
      end
      size_d = clamp[FILL_W-1:0];
      widx_d = '0;
      ridx_d = '0;
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      widx_q       <= '0;
      ridx_q       <= '0;
      full_q       <= 1'b0;
      size_q       <= FILL_W'(DEPTH);
      didx_q       <= '0;
      remain_q     <= '0;
      dfill_q      <= '0;
      dfull_q      <= 1'b0;
      drain_q      <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_meta_q  <= '0;
    end else begin
      state_q      <= state_d;
      widx_q       <= widx_d;
      ridx_q       <= ridx_d;
      full_q       <= full_d;
      size_q       <= size_d;
      didx_q       <= didx_d;
      remain_q     <= remain_d;
      dfill_q      <= dfill_d;
      dfull_q      <= dfull_d;
      drain_q      <= drain_d;
      pend_valid_q <= pend_valid_d;
      pend_meta_q  <= pend_meta_d;
    end
  end

  assign pend_valid_o = pend_valid_q;
  assign pend_meta_o  = pend_meta_q;

endmodule

FILE: src/obrb_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obrb_out_fifo
// Small result queue that decouples the output port from the store reads.
// ----------------------------------------------------------------------------
module obrb_out_fifo
  import obrb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  res_item_t         item_i,
  output logic              valid_o,
  input  logic              ready_i,
  output res_item_t         item_o,
  output logic [OCNT_W-1:0] count_o
);

  res_item_t         slots [OUT_DEPTH];
  logic [OPTR_W-1:0] wptr_q, wptr_d;
  logic [OPTR_W-1:0] rptr_q, rptr_d;
  logic [OCNT_W-1:0] cnt_q, cnt_d;
  logic              pop;

  function automatic logic [OPTR_W-1:0] wrap_inc(input logic [OPTR_W-1:0] p);
    return (p == OPTR_W'(OUT_DEPTH - 1)) ? '0 : p + OPTR_W'(1);
  endfunction

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign item_o  = slots[rptr_q];
  assign count_o = cnt_q;

  always_comb begin
    wptr_d = push_i ? wrap_inc(wptr_q) : wptr_q;
    rptr_d = pop ? wrap_inc(rptr_q) : rptr_q;
    cnt_d  = cnt_q + OCNT_W'(push_i) - OCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots[wptr_q] <= item_i;
    end
  end

endmodule

FILE: src/overwriting_byte_ring_buffer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwriting_byte_ring_buffer_top
// Byte FIFO on a circular RAM that overwrites its oldest byte when full.
// ----------------------------------------------------------------------------
// Timing: each result is registered as a descriptor beside its RAM read, then
//   in the result queue before the master side; dump and drain pass via ST_DUMP.
// Throughput: push, pop and peek take one word per cycle while the queue has room;
//   dump and drain take no new word until the single RAM read port has read each stored byte.
// Reset: asynchronous, active low; the store is empty and the size is DEPTH.
//   The RAM contents are not cleared, and no entry is read before it is written.
// ----------------------------------------------------------------------------
module overwriting_byte_ring_buffer_top
  import obrb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Size register write port.
  input  logic                   cfg_we_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  // Command stream.
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [FUNC_W-1:0]      s_axis_tuser_i,   // [2:0] func
  input  logic                   s_axis_tlast_i,   // last_in
  // Result stream.
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata_o,   // [7:0] out_byte, [14:8] fill_count,
                                                   // [15] is_full
  output logic [0:0]             m_axis_tuser_o,   // [0] was_empty
  output logic                   m_axis_tlast_o    // last_out
);

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;
  logic              pend_valid;
  res_meta_t         pend_meta;
  res_item_t         pend_item;
  res_item_t         out_item;
  logic [OCNT_W-1:0] fifo_cnt;
  logic [OCNT_W:0]   occupancy;
  logic              room;

  // The controller issues a new result only when the queue can absorb it,
  // counting the descriptor that is still waiting for its RAM read.
  assign occupancy = {1'b0, fifo_cnt} + (OCNT_W + 1)'(pend_valid);
  assign room      = (occupancy < (OCNT_W + 1)'(OUT_DEPTH));

  obrb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_func_i    (s_axis_tuser_i),
    .in_data_i    (s_axis_tdata_i),
    .in_last_i    (s_axis_tlast_i),
    .room_i       (room),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .pend_valid_o (pend_valid),
    .pend_meta_o  (pend_meta)
  );

  // Pushes and reads never target the store in the same cycle: a push word
  // only writes, and a read issued in the cycle after a push sees the written byte.
  obrb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // The descriptor and the RAM read data line up in the same cycle.
  always_comb begin
    pend_item.data      = pend_meta.use_ram ? mem_rdata : '0;
    pend_item.fill      = pend_meta.fill;
    pend_item.was_empty = pend_meta.was_empty;
    pend_item.full      = pend_meta.full;
    pend_item.last      = pend_meta.last;
  end

  obrb_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (pend_valid),
    .item_i  (pend_item),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .item_o  (out_item),
    .count_o (fifo_cnt)
  );

  assign m_axis_tdata_o = {out_item.full, OUT_FILL_W'(out_item.fill), out_item.data};
  assign m_axis_tuser_o = out_item.was_empty;
  assign m_axis_tlast_o = out_item.last;

endmodule

FILE: src/obrb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obrb_checker
// Port-level checks of the ring buffer result stream.
// ----------------------------------------------------------------------------
module obrb_checker
  import obrb_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_tvalid_i,
  input logic                   m_tready_i,
  input logic [TDATA_OUT_W-1:0] m_tdata_i,
  input logic [0:0]             m_tuser_i,
  input logic                   m_tlast_i
);

  // An empty-store result is a single closing word whose tdata fields are all zero.
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tuser_i[0] |-> m_tlast_i && (m_tdata_i == '0))
    else $error("empty-store result is not a single zero word");

  // A full store always reports a nonzero fill count.
  a_full_has_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tdata_i[15] |-> (m_tdata_i[14:8] != '0))
    else $error("full flag with zero fill count");

  // The fill count never exceeds the store depth.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> (m_tdata_i[14:8] <= OUT_FILL_W'(DEPTH)))
    else $error("fill count beyond store depth");

  // A stalled result word is held unchanged.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i) &&
      $stable(m_tuser_i) && $stable(m_tlast_i))
    else $error("result word changed while stalled");

endmodule

bind overwriting_byte_ring_buffer_top obrb_checker u_obrb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tuser_i  (m_axis_tuser_o),
  .m_tlast_i  (m_axis_tlast_o)
);

FILE: tb/tb_overwriting_byte_ring_buffer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_overwriting_byte_ring_buffer_top
// Self-checking bench for the overwriting byte ring buffer. A clocked driver
// feeds command words from a queue, a clocked monitor runs a local model of
// the circular store on every accepted word and compares each result word
// field by field. Sizes are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_overwriting_byte_ring_buffer_top;
  import obrb_pkg::*;

  // Cycles without any handshake or size write before the run is abandoned.
  localparam int unsigned STALL_LIMIT = 2000;
  // Cycles allowed for words still inside the pipeline once nothing is due.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_PRINTED = 100;

  // One command word as the driver sends it.
  typedef struct {
    logic [FUNC_W-1:0] fn;
    logic [BYTE_W-1:0] data;
    logic              last;
    bit                hold;   // wait for every due result before sending
  } ring_cmd_t;

  // One result word as the monitor expects it.
  typedef struct packed {
    logic [BYTE_W-1:0]     data;
    logic [OUT_FILL_W-1:0] fill;
    logic                  empty;
    logic                  full;
    logic                  last;
  } ring_res_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [TDATA_IN_W-1:0]  s_tdata = '0;
  logic [FUNC_W-1:0]      s_tuser = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_tdata;
  logic [0:0]             m_tuser;
  logic                   m_tlast;

  overwriting_byte_ring_buffer_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tlast_o (m_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Command words waiting to be sent, and result words still due.
  ring_cmd_t cmd_q[$];
  ring_res_t ring_res_q[$];

  int unsigned err_count = 0;
  int unsigned res_count = 0;
  int unsigned stuck_cycles = 0;
  int unsigned s_gap = 0;
  int unsigned m_gap = 0;
  bit          calm = 1'b0;   // no idling on either side in the closing phase
  bit          s_fire = 1'b0; // command handshake at the most recent rising edge

  // Local copy of the circular store.
  logic [BYTE_W-1:0] ring_mem [DEPTH];
  int unsigned       wr_ptr = 0;
  int unsigned       rd_ptr = 0;
  bit                ring_full = 1'b0;
  logic [CFG_W-1:0]  size_reg = CFG_W'(DEPTH);

  task automatic report_mismatch(string msg);
    if (err_count < MAX_PRINTED)
      $display("MISMATCH at %0t ns, result %0d: %s", $time, res_count, msg);
    err_count++;
  endtask

  // A size of zero behaves as one slot, anything above the depth as the depth.
  function automatic int unsigned ring_cap();
    if (size_reg == '0) return 1;
    if (size_reg > DEPTH) return DEPTH;
    return 32'(size_reg);
  endfunction

  function automatic int unsigned ring_next(int unsigned p);
    return (p + 1 >= ring_cap()) ? 0 : p + 1;
  endfunction

  function automatic int unsigned ring_level();
    if (wr_ptr == rd_ptr) return ring_full ? ring_cap() : 0;
    if (wr_ptr > rd_ptr) return wr_ptr - rd_ptr;
    return ring_cap() - rd_ptr + wr_ptr;
  endfunction

  // Applies one accepted command to the local store and queues the result
  // words it should produce.
  task automatic predict_ring_op(ring_cmd_t c);
    int unsigned n;
    int unsigned p;
    ring_res_t   r;
    n = ring_level();
    r = '0;
    case (c.fn)
      FUNC_PUSH: begin
        ring_mem[IDX_W'(wr_ptr)] = c.data;
        // A push into a full store drops the oldest byte.
        if (ring_full) rd_ptr = ring_next(rd_ptr);
        wr_ptr = ring_next(wr_ptr);
        ring_full = (wr_ptr == rd_ptr);
        // Only the closing byte of a batch reports status.
        if (c.last) begin
          r.fill = OUT_FILL_W'(ring_level());
          r.full = ring_full;
          r.last = 1'b1;
          ring_res_q.push_back(r);
        end
      end
      FUNC_POP, FUNC_PEEK, FUNC_DUMP, FUNC_DRAIN: begin
        if (n == 0) begin
          // Reading an empty store gives a single flagged status word.
          r.empty = 1'b1;
          r.last  = 1'b1;
          ring_res_q.push_back(r);
        end else if (c.fn == FUNC_POP || c.fn == FUNC_PEEK) begin
          r.data = ring_mem[IDX_W'(rd_ptr)];
          if (c.fn == FUNC_POP) begin
            rd_ptr = ring_next(rd_ptr);
            ring_full = 1'b0;
          end
          r.fill = OUT_FILL_W'(ring_level());
          r.full = ring_full;
          r.last = 1'b1;
          ring_res_q.push_back(r);
        end else begin
          // A dump reports the untouched store; a drain reports it emptied.
          p = rd_ptr;
          for (int unsigned i = 0; i < n; i++) begin
            r.data = ring_mem[IDX_W'(p)];
            r.fill = (c.fn == FUNC_DUMP) ? OUT_FILL_W'(n) : '0;
            r.full = (c.fn == FUNC_DUMP) && ring_full;
            r.last = (i + 1 == n);
            ring_res_q.push_back(r);
            p = ring_next(p);
          end
          if (c.fn == FUNC_DRAIN) begin
            wr_ptr = 0;
            rd_ptr = 0;
            ring_full = 1'b0;
          end
        end
      end
      default: ;  // unknown operations leave everything as it is
    endcase
  endtask

  // Monitor: samples both handshakes and the size port at the rising edge.
  always @(posedge clk_i) begin
    ring_res_t got;
    ring_res_t want;
    bit        m_fire;
    ring_cmd_t c;
    s_fire = rst_ni && s_tvalid && s_tready;
    m_fire = rst_ni && m_tvalid && m_tready;
    if (rst_ni && cfg_we) begin
      // Any size write empties the store.
      size_reg  = cfg_wdata;
      wr_ptr    = 0;
      rd_ptr    = 0;
      ring_full = 1'b0;
    end
    if (s_fire) begin
      c.fn   = s_tuser;
      c.data = s_tdata;
      c.last = s_tlast;
      c.hold = 1'b0;
      predict_ring_op(c);
    end
    if (m_fire) begin
      got.data  = m_tdata[7:0];
      got.fill  = m_tdata[14:8];
      got.full  = m_tdata[15];
      got.empty = m_tuser[0];
      got.last  = m_tlast;
      if (ring_res_q.size() == 0) begin
        report_mismatch($sformatf("result word %h with nothing due", got));
      end else begin
        want = ring_res_q.pop_front();
        if (got.data !== want.data)
          report_mismatch($sformatf("out_byte %h, want %h", got.data, want.data));
        if (got.fill !== want.fill)
          report_mismatch($sformatf("fill_count %0d, want %0d", got.fill, want.fill));
        if (got.empty !== want.empty)
          report_mismatch($sformatf("was_empty %b, want %b", got.empty, want.empty));
        if (got.full !== want.full)
          report_mismatch($sformatf("is_full %b, want %b", got.full, want.full));
        if (got.last !== want.last)
          report_mismatch($sformatf("last_out %b, want %b", got.last, want.last));
      end
      res_count++;
    end
    // Watchdog: any handshake or size write counts as progress.
    if (!rst_ni || s_fire || m_fire || cfg_we) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles == STALL_LIMIT) begin
        $display("watchdog expired at %0t ns", $time);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Command driver: a new word goes out at the falling edge once the slot is
  // free, after any random gap has run out. A held word waits until every
  // due result word has been taken.
  always @(negedge clk_i) begin
    ring_cmd_t c;
    if (rst_ni && (!s_tvalid || s_fire)) begin
      if (s_gap > 0) begin
        s_gap--;
        s_tvalid <= 1'b0;
      end else if (cmd_q.size() > 0 && !(cmd_q[0].hold && ring_res_q.size() > 0)) begin
        c = cmd_q.pop_front();
        s_tuser  <= c.fn;
        s_tdata  <= c.data;
        s_tlast  <= c.last;
        s_tvalid <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) s_gap = $urandom_range(1, 11);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result side back-pressure in random bursts.
  always @(negedge clk_i) begin
    if (m_gap > 0) begin
      m_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!calm && $urandom_range(0, 7) == 0) m_gap = $urandom_range(1, 11);
    end
  end

  task automatic queue_cmd(logic [FUNC_W-1:0] fn, logic [BYTE_W-1:0] data, logic last);
    ring_cmd_t c;
    c.fn   = fn;
    c.data = data;
    c.last = last;
    c.hold = 1'b0;
    cmd_q.push_back(c);
  endtask

  // Random commands with a chosen share of pushes; the rest spreads over the
  // read operations and a few unknown codes.
  task automatic queue_random(int unsigned count, int unsigned push_pct, bit hold_first);
    ring_cmd_t   c;
    int unsigned roll;
    for (int unsigned k = 0; k < count; k++) begin
      c.data = BYTE_W'($urandom_range(0, 255));
      c.last = 1'($urandom_range(0, 1));
      c.hold = (hold_first && k == 0) || ($urandom_range(0, 39) == 0);
      if ($urandom_range(0, 99) < push_pct) begin
        c.fn = FUNC_PUSH;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 35)      c.fn = FUNC_POP;
        else if (roll < 55) c.fn = FUNC_PEEK;
        else if (roll < 75) c.fn = FUNC_DUMP;
        else if (roll < 90) c.fn = FUNC_DRAIN;
        else                c.fn = FUNC_W'($urandom_range(5, 7));
      end
      cmd_q.push_back(c);
    end
  endtask

  // Waits until nothing is queued, in flight or due, then lets pushes that
  // produce no result leave the pipeline. The check runs at the rising edge,
  // where the driver's outputs of the preceding falling edge have settled.
  task automatic settle();
    @(posedge clk_i);
    while (cmd_q.size() != 0 || s_tvalid || ring_res_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_size(logic [CFG_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reads of an empty store, unknown codes, a short batch with
    // every read operation, then a drain and a pop after it.
    queue_cmd(FUNC_POP,   8'h00, 1'b0);
    queue_cmd(FUNC_PEEK,  8'hFF, 1'b1);
    queue_cmd(FUNC_DUMP,  8'h00, 1'b0);
    queue_cmd(FUNC_DRAIN, 8'h00, 1'b1);
    queue_cmd(3'd5, 8'hC3, 1'b1);
    queue_cmd(3'd6, 8'h3C, 1'b0);
    queue_cmd(3'd7, 8'hFF, 1'b1);
    queue_cmd(FUNC_PUSH,  8'h00, 1'b0);
    queue_cmd(FUNC_PUSH,  8'hFF, 1'b1);
    queue_cmd(FUNC_PUSH,  8'hA5, 1'b0);
    queue_cmd(FUNC_PEEK,  8'h00, 1'b0);
    queue_cmd(FUNC_DUMP,  8'h00, 1'b0);
    queue_cmd(FUNC_POP,   8'h00, 1'b0);
    queue_cmd(FUNC_PUSH,  8'h5A, 1'b1);
    queue_cmd(FUNC_DRAIN, 8'h00, 1'b0);
    queue_cmd(FUNC_POP,   8'h00, 1'b0);

    // One slot: the second push overwrites the first, and a pop must clear
    // the full flag.
    write_size(7'd1);
    queue_cmd(FUNC_PUSH, 8'h12, 1'b1);
    queue_cmd(FUNC_PUSH, 8'h34, 1'b1);
    queue_cmd(FUNC_PEEK, 8'h00, 1'b0);
    queue_cmd(FUNC_DUMP, 8'h00, 1'b0);
    queue_cmd(FUNC_POP,  8'h00, 1'b0);
    queue_cmd(FUNC_PEEK, 8'h00, 1'b0);

    // A size of zero must behave as one slot.
    write_size(7'd0);
    queue_cmd(FUNC_PUSH,  8'h80, 1'b1);
    queue_cmd(FUNC_PUSH,  8'h7F, 1'b1);
    queue_cmd(FUNC_DRAIN, 8'h00, 1'b0);

    // Oversized value clamps to the full depth: fill past capacity so the
    // oldest bytes are overwritten, then dump the whole store at once.
    write_size(7'd127);
    for (int k = 0; k < 66; k++) queue_cmd(FUNC_PUSH, BYTE_W'($urandom_range(0, 255)),
                                           1'($urandom_range(0, 1)));
    queue_cmd(FUNC_DUMP, 8'h00, 1'b0);
    queue_random(40, 60, 1'b0);

    // Tiny store with constant wrap; its first word waits for the pipe to empty.
    write_size(7'd2);
    queue_random(40, 55, 1'b1);

    write_size(7'd64);
    queue_random(60, 75, 1'b0);

    write_size(CFG_W'($urandom_range(3, 63)));
    queue_random(40, 55, 1'b0);

    // Closing phase runs at full rate on both sides.
    write_size(7'd7);
    calm = 1'b1;
    queue_random(40, 55, 1'b0);

    settle();
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: overwriting_byte_ring_buffer_top.f
src/obrb_pkg.sv
src/obrb_ram.sv
src/obrb_ctrl.sv
src/obrb_out_fifo.sv
src/overwriting_byte_ring_buffer_top.sv
src/obrb_checker.sv
tb/tb_overwriting_byte_ring_buffer_top.sv
